/* src/ets_pkg.sv */
// shared types, codes and constants of the event and timeout task scheduler
`timescale 1ns / 1ps

package ets_pkg;

    localparam int ETS_MAX_TASKS = 8;

    localparam logic [1:0] ACT_WAIT  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_SWITCH = 2'd1;
    localparam logic [1:0] ST_IDLE   = 2'd2;

    localparam logic [1:0] ADDR_NUM_TASKS = 2'd0;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] event_mask;
        logic [30:0] timeout;
        logic [15:0] tick_count;
        logic [7:0]  task_mask;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  running_task;
        logic [31:0] resumed_wait_events;
        logic [31:0] tick_now;
    } result_t;

    typedef struct packed {
        logic [30:0] expire;
        logic [31:0] wait_mask;
    } entry_t;

endpackage

/* src/ets_entry_ram.sv */
// per-task entry memory (wait mask and timeout) with valid bits and write-first read
`timescale 1ns / 1ps

module ets_entry_ram
    import ets_pkg::*;
#(
    parameter int DEPTH = ETS_MAX_TASKS,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    input  logic [DEPTH-1:0] clr,
    output entry_t           rdata
);

    entry_t           entry_mem [DEPTH];
    entry_t           rd_reg;
    entry_t           byp_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             hit_reg;
    logic             byp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg       <= entry_mem[raddr];
            byp_data_reg <= wdata;
        end
    end

    always_comb
    begin
        valid_next = valid_reg & ~clr;
        if (we)
        begin
            valid_next = valid_next | (DEPTH'(1) << waddr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
                byp_reg <= we && (waddr == raddr);
            end
        end
    end

    // never-written entries read as zero
    assign rdata = byp_reg ? byp_data_reg : (hit_reg ? rd_reg : '0);

endmodule

/* src/ets_rr_pick.sv */
// round-robin pick of the next ready task from a start index with wraparound
`timescale 1ns / 1ps

module ets_rr_pick
#(
    parameter int N = 8,
    localparam int IW = $clog2(N)
)
(
    input  logic [N-1:0]  cand,
    input  logic [IW-1:0] start,
    output logic          found,
    output logic [IW-1:0] pick
);

    logic [N-1:0]  hi_cand;
    logic [IW-1:0] hi_idx;
    logic [IW-1:0] lo_idx;

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            hi_cand[j] = cand[j] && (IW'(j) >= start);
        end
    end

    always_comb
    begin
        hi_idx = '0;
        lo_idx = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (hi_cand[j])
            begin
                hi_idx = IW'(j);
            end
            if (cand[j])
            begin
                lo_idx = IW'(j);
            end
        end
    end

    assign found = |cand;
    assign pick  = (|hi_cand) ? hi_idx : lo_idx;

endmodule

/* src/ets_ctrl.sv */
// scheduler sequencer: ready bits, current task, tick total and entry sweeps
`timescale 1ns / 1ps

module ets_ctrl
    import ets_pkg::*;
#(
    parameter int MAX_TASKS = ETS_MAX_TASKS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic [3:0] num_tasks,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SW    = (MAX_TASKS > 8) ? MAX_TASKS : 8;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    item_t                item_reg;
    item_t                item_next;
    logic [MAX_TASKS-1:0] ready_reg;
    logic [MAX_TASKS-1:0] ready_next;
    logic [IDX_W-1:0]     cur_reg;
    logic [IDX_W-1:0]     cur_next;
    logic [31:0]          tick_reg;
    logic [31:0]          tick_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    logic [CNT_W-1:0]     count;
    logic [CNT_W-1:0]     cur_p1;
    logic [IDX_W-1:0]     start_idx;
    logic [MAX_TASKS-1:0] below_n;
    logic [MAX_TASKS-1:0] cur_onehot;
    logic [MAX_TASKS-1:0] ready_eff;
    logic [MAX_TASKS-1:0] stop_vec;
    logic [SW-1:0]        tmask_wide;
    logic                 tmo_nz;
    logic                 found;
    logic [IDX_W-1:0]     pick_idx;
    logic                 last;
    logic                 wake;
    logic [30:0]          tick31;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
    logic [MAX_TASKS-1:0] clr;
    entry_t               rdata;
    entry_t               swept;

    // effective task count
    always_comb
    begin
        if (num_tasks == 4'd0)
        begin
            count = CNT_W'(1);
        end
        else if (32'(num_tasks) > 32'(MAX_TASKS))
        begin
            count = CNT_W'(MAX_TASKS);
        end
        else
        begin
            count = CNT_W'(num_tasks);
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_TASKS; j++)
        begin
            below_n[j] = (CNT_W'(j) < count);
        end
    end

    assign cur_onehot = MAX_TASKS'(1) << cur_reg;
    assign tmo_nz     = (item_reg.timeout != 31'd0);
    assign ready_eff  = tmo_nz ? (ready_reg & ~cur_onehot) : ready_reg;
    assign tmask_wide = SW'(item_reg.task_mask);
    assign stop_vec   = tmask_wide[MAX_TASKS-1:0] & ~cur_onehot;
    assign cur_p1     = CNT_W'(cur_reg) + CNT_W'(1);
    assign start_idx  = (cur_p1 >= count) ? '0 : IDX_W'(cur_p1);
    assign last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count);
    assign tick31     = 31'(item_reg.tick_count);

    ets_rr_pick #(
        .N (MAX_TASKS)
    ) u_pick (
        .cand  (ready_eff & below_n),
        .start (start_idx),
        .found (found),
        .pick  (pick_idx)
    );

    ets_entry_ram #(
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .clr   (clr),
        .rdata (rdata)
    );

    // per-entry update during tick and event sweeps
    always_comb
    begin
        swept = rdata;
        wake  = 1'b0;
        if (item_reg.action == ACT_TICK)
        begin
            if (rdata.expire != 31'd0)
            begin
                if (tick31 >= rdata.expire)
                begin
                    wake         = 1'b1;
                    swept.expire = '0;
                end
                else
                begin
                    swept.expire = rdata.expire - tick31;
                end
            end
        end
        else
        begin
            if ((rdata.wait_mask & item_reg.event_mask) != 32'd0)
            begin
                wake            = 1'b1;
                swept.wait_mask = rdata.wait_mask & ~item_reg.event_mask;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        ready_next  = ready_reg;
        cur_next    = cur_reg;
        tick_next   = tick_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = '{expire: item_reg.timeout, wait_mask: item_reg.event_mask};
        re          = 1'b0;
        raddr       = cur_reg;
        clr         = '0;
        res_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_NONE;
                re          = 1'b1;
                case (item_reg.action)
                    ACT_WAIT:
                    begin
                        we         = tmo_nz;
                        ready_next = ready_eff;
                        if (found)
                        begin
                            cur_next    = pick_idx;
                            raddr       = pick_idx;
                            status_next = ST_SWITCH;
                        end
                        else
                        begin
                            status_next = ST_IDLE;
                        end
                        state_next = S_RESULT;
                    end
                    ACT_TICK,
                    ACT_EVENT:
                    begin
                        if ((item_reg.action == ACT_TICK) && (item_reg.tick_count == 16'd0))
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            if (item_reg.action == ACT_TICK)
                            begin
                                tick_next = tick_reg + 32'(item_reg.tick_count);
                            end
                            raddr      = '0;
                            idx_next   = '0;
                            state_next = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        ready_next = ready_reg & ~stop_vec;
                        clr        = stop_vec & below_n;
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SWEEP:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = swept;
                if (wake)
                begin
                    ready_next = ready_reg | (MAX_TASKS'(1) << idx_reg);
                end
                re = 1'b1;
                if (last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    raddr    = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ready_reg  <= '1;
            cur_reg    <= '0;
            tick_reg   <= '0;
            idx_reg    <= '0;
            status_reg <= ST_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            ready_reg  <= ready_next;
            cur_reg    <= cur_next;
            tick_reg   <= tick_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign in_ready                = (state_reg == S_IDLE);
    assign res.status              = status_reg;
    assign res.running_task        = 3'(cur_reg);
    assign res.resumed_wait_events = rdata.wait_mask;
    assign res.tick_now            = tick_reg;

endmodule

/* src/event_timeout_task_scheduler.sv */
// top level of the event and timeout task scheduler: config port, stream ports, output register
`timescale 1ns / 1ps

// Round-robin task scheduler with per-task event masks and timeouts. Each input beat
// carries an action in s_axis_tuser: wait/yield (sleeps the current task when timeout is
// nonzero, then picks the next ready task from current+1, current last), tick (adds
// tick_count and expires timeouts), event (wakes tasks waiting on any posted bit) or stop
// (parks the masked tasks other than the current one). Every beat yields one result beat
// with the status in m_axis_tuser and the running task, its remaining wait mask and the
// tick total in m_axis_tdata. Items are handled one at a time: wait, stop and zero-tick
// items need no sweep; for tick and event items the per-task entry memory of the n
// active tasks is swept one entry per cycle through its single read-modify-write path.
// Entries start out zero through per-entry valid bits, so no clearing pass follows
// reset. num_tasks (register 0, byte address 0) sets n; zero acts as one and values
// above MAX_TASKS act as MAX_TASKS. Write it only while idle.

module event_timeout_task_scheduler
    import ets_pkg::*;
#(
    parameter int MAX_TASKS = ETS_MAX_TASKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // event_mask[31:0], timeout[62:32], tick_count[78:63], task_mask[86:79], zero pad
    input  logic [87:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_task[2:0], resumed_wait_events[34:3], tick_now[66:35], zero pad
    output logic [71:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    logic [3:0] num_tasks_reg;
    logic       cfg_wr;
    item_t      item;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    logic       out_valid_reg;
    result_t    out_data_reg;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_NUM_TASKS);
    assign prdata = (paddr == ADDR_NUM_TASKS) ? {28'd0, num_tasks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tasks_reg <= 4'd1;
        end
        else if (cfg_wr)
        begin
            num_tasks_reg <= pwdata[3:0];
        end
    end

    assign item.action     = s_axis_tuser;
    assign item.event_mask = s_axis_tdata[31:0];
    assign item.timeout    = s_axis_tdata[62:32];
    assign item.tick_count = s_axis_tdata[78:63];
    assign item.task_mask  = s_axis_tdata[86:79];

    ets_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_tasks (num_tasks_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.status;
    assign m_axis_tdata  = {5'd0, out_data_reg.tick_now, out_data_reg.resumed_wait_events,
                            out_data_reg.running_task};

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new beat taken while an item is in progress");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while output register busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_NONE || m_axis_tuser == ST_SWITCH
                           || m_axis_tuser == ST_IDLE))
        else $error("undefined status on result beat");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> num_tasks_reg == $past(pwdata[3:0]))
        else $error("num_tasks write lost");

endmodule
